FILE: hw/rtl/lmrs_pkg.sv
// Package for the LED matrix row-scan serializer.
// Holds sizes, item/result types, FSM state codes and controller commands.
// No dependencies.
package lmrs_pkg;

	localparam int ROWS   = 16;
	localparam int COLS   = 8;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int BITS   = COLS + ROWS;
	localparam int CNT_W  = $clog2(BITS);

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_SCAN  = 1'b1;

	typedef struct packed {
		logic       action;
		logic [3:0] row_index;
		logic [2:0] column_index;
		logic       pixel_on;
	} item_t;

	typedef struct packed {
		logic serial_bit;
		logic is_latch;
		logic last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SHIFT = 3'b010,
		ST_LATCH = 3'b100
	} state_t;

	typedef struct packed {
		logic write_px;
		logic load_row;
		logic shift;
		logic latch;
	} cmd_t;

endpackage

FILE: hw/rtl/lmrs_ctrl.sv
// Controller FSM for the LED matrix row-scan serializer.
// Sequences shift and latch steps; issues commands to lmrs_dp.
// Depends on lmrs_pkg.
module lmrs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   action,
	output logic                   busy,
	output logic                   strobe,
	output lmrs_pkg::cmd_t         cmd
);

	localparam logic [lmrs_pkg::CNT_W-1:0] CNT_LAST = lmrs_pkg::CNT_W'(lmrs_pkg::BITS - 1);

	lmrs_pkg::state_t              state_q, state_d;
	logic [lmrs_pkg::CNT_W-1:0]    cnt_q;
	logic                          accept;

	assign accept = start && (state_q == lmrs_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			lmrs_pkg::ST_IDLE: begin
				if (accept && action == lmrs_pkg::ACT_SCAN)
					state_d = lmrs_pkg::ST_SHIFT;
			end
			lmrs_pkg::ST_SHIFT: begin
				if (cnt_q == CNT_LAST)
					state_d = lmrs_pkg::ST_LATCH;
			end
			lmrs_pkg::ST_LATCH: begin
				state_d = lmrs_pkg::ST_IDLE;
			end
			default: begin
				state_d = lmrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmrs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == lmrs_pkg::ST_SHIFT) && (cnt_q != CNT_LAST))
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	assign busy         = (state_q != lmrs_pkg::ST_IDLE);
	assign strobe       = (state_q == lmrs_pkg::ST_SHIFT) || (state_q == lmrs_pkg::ST_LATCH);
	assign cmd.write_px = accept && (action == lmrs_pkg::ACT_WRITE);
	assign cmd.load_row = accept && (action == lmrs_pkg::ACT_SCAN);
	assign cmd.shift    = (state_q == lmrs_pkg::ST_SHIFT);
	assign cmd.latch    = (state_q == lmrs_pkg::ST_LATCH);

	a_latch_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lmrs_pkg::ST_LATCH) |-> $past(state_q == lmrs_pkg::ST_SHIFT))
		else $error("latch step not preceded by shift step");

	a_idle_after_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lmrs_pkg::ST_LATCH) |=> (state_q == lmrs_pkg::ST_IDLE))
		else $error("controller did not return to idle after latch");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("shift count beyond run length");

	a_no_cmd_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.write_px, cmd.load_row, cmd.shift, cmd.latch}))
		else $error("controller issued overlapping commands");

endmodule

FILE: hw/rtl/lmrs_dp.sv
// Datapath for the LED matrix row-scan serializer.
// Frame store, scan row counter and the output shift register.
// Depends on lmrs_pkg; driven by commands from lmrs_ctrl.
module lmrs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lmrs_pkg::cmd_t       cmd,
	input  lmrs_pkg::item_t      item,
	output lmrs_pkg::result_t    result
);

	logic [lmrs_pkg::COLS-1:0]  frame_q [lmrs_pkg::ROWS];
	logic [lmrs_pkg::ROW_W-1:0] scan_row_q;
	logic [lmrs_pkg::ROW_W-1:0] row_next;
	logic [lmrs_pkg::BITS-1:0]  sr_q;
	logic [lmrs_pkg::ROWS-1:0]  row_sel;
	logic                       wr_in_range;
	logic [lmrs_pkg::ROW_W-1:0] wr_row;
	logic [lmrs_pkg::COL_W-1:0] wr_col;

	assign wr_in_range = (32'(item.row_index) < lmrs_pkg::ROWS) &&
	                     (32'(item.column_index) < lmrs_pkg::COLS);
	assign wr_row = lmrs_pkg::ROW_W'(item.row_index);
	assign wr_col = lmrs_pkg::COL_W'(item.column_index);

	assign row_next = (32'(scan_row_q) == lmrs_pkg::ROWS - 1) ? '0 : scan_row_q + 1'b1;
	// row-select word goes out LSB first with bit (ROWS-1-row) set; reversed, that is 1 << row
	assign row_sel  = lmrs_pkg::ROWS'(1) << row_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < lmrs_pkg::ROWS; r++)
				frame_q[r] <= '0;
			scan_row_q <= '0;
		end else begin
			if (cmd.write_px && wr_in_range)
				frame_q[wr_row][wr_col] <= item.pixel_on;
			if (cmd.load_row)
				scan_row_q <= row_next;
		end
	end

	// column bits are active low, highest column shifted first
	always_ff @(posedge clk) begin
		if (cmd.load_row)
			sr_q <= {~frame_q[row_next], row_sel};
		else if (cmd.shift)
			sr_q <= {sr_q[lmrs_pkg::BITS-2:0], 1'b0};
	end

	assign result.serial_bit = cmd.shift & sr_q[lmrs_pkg::BITS-1];
	assign result.is_latch   = cmd.latch;
	assign result.last       = cmd.latch;

endmodule

FILE: hw/rtl/led_matrix_row_scan_serializer.sv
// LED matrix row-scan serializer, top level: lmrs_ctrl + lmrs_dp.
// Write item: no results, busy stays low.
// Scan tick: busy until the latch result is out; results start the cycle after the transfer, one per cycle
// (24 shift bits then the latch); the next start is taken only once the controller is idle again.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (arst_n low, async): frame store dark, scan row 0, controller idle.
module led_matrix_row_scan_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  lmrs_pkg::item_t      item,
	output logic                 busy,
	output logic                 strobe,
	output lmrs_pkg::result_t    result
);

	lmrs_pkg::cmd_t cmd;

	lmrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.busy   (busy),
		.strobe (strobe),
		.cmd    (cmd)
	);

	lmrs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule
